// File: sv/bf16esp_pkg.sv
// ----------------------------------------------------------------------------
// bf16esp_pkg
// Shared types and constants of the BF16 exponent-split packer.
// ----------------------------------------------------------------------------
package bf16esp_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_CODES_LOW  = 3'd0;
   localparam logic [2:0] CSR_CODES_HIGH = 3'd1;
   localparam logic [2:0] CSR_CODES_USED = 3'd2;
   localparam logic [2:0] CSR_ROW_LENGTH = 3'd3;
   localparam logic [2:0] CSR_MARKER     = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_PATCH = 2'd1;
   localparam logic [1:0] KIND_COUNT = 2'd2;

   localparam logic [15:0] MAX_ROW_LENGTH = 16'd65535;
   localparam logic [30:0] PATCH_TOTAL_MAX = 31'h7FFF_FFFF;

   localparam int NUM_CODES   = 15;
   localparam int MAX_RESULTS = 4;
   localparam int WORD_BITS   = 32;
   localparam int UNIT_BITS   = 12;

   typedef struct packed {
      logic [15:0] value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        packed_word;
      logic [15:0]        patch_column;
      logic [15:0]        patch_correct;
      logic signed [15:0] patch_wrong;
      logic [30:0]        row_offset;
      logic               final_res;
   } rsp_type;

endpackage

// File: sv/bf16_exponent_split_packer_top.sv
// Flow: a request enters the input register, then its results are loaded into a
// four-entry result buffer once it is free, and leave one per cycle while not stalled.
// Throughput: one request per cycle while each request yields at most one result
// and rsp_stall is low; a request with n results (0 to 4) holds the buffer until all leave.
// Reset (synchronous, active high) clears the pack state, the buffers and the
// configuration registers to their documented defaults; no clearing pass.
// ----------------------------------------------------------------------------
// bf16_exponent_split_packer_top
// Maps each BF16 exponent onto a 4-bit table code, packs 12-bit units into
// 32-bit words and emits patch entries and per-row patch counts.
// ----------------------------------------------------------------------------
module bf16_exponent_split_packer_top (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bf16esp_pkg::req_type req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bf16esp_pkg::rsp_type rsp_data,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data
);
   import bf16esp_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are expected only while the block
   // is idle; a write takes effect from the next cycle.
   // ---------------------------------------------------------------------
   logic [63:0]        codes_low_ff,  codes_low_in;
   logic [55:0]        codes_high_ff, codes_high_in;
   logic [3:0]         codes_used_ff, codes_used_in;
   logic [15:0]        row_length_ff, row_length_in;
   logic signed [15:0] marker_ff,     marker_in;

   assign csr_ready = 1'b1;

   always_comb begin
      codes_low_in  = codes_low_ff;
      codes_high_in = codes_high_ff;
      codes_used_in = codes_used_ff;
      row_length_in = row_length_ff;
      marker_in     = marker_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CODES_LOW:  codes_low_in  = csr_data;
            CSR_CODES_HIGH: codes_high_in = csr_data[55:0];
            CSR_CODES_USED: codes_used_in = csr_data[3:0];
            CSR_ROW_LENGTH: row_length_in = csr_data[15:0];
            CSR_MARKER:     marker_in     = csr_data[15:0];
            default: ;      // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_low_ff  <= '0;
         codes_high_ff <= '0;
         codes_used_ff <= '0;
         row_length_ff <= 16'd1;
         marker_ff     <= '0;
      end else begin
         codes_low_ff  <= codes_low_in;
         codes_high_ff <= codes_high_in;
         codes_used_ff <= codes_used_in;
         row_length_ff <= row_length_in;
         marker_ff     <= marker_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register. It takes a request whenever it is empty or its
   // content moves into the result buffer in the same cycle, so a new
   // request is taken while results of the previous one still wait.
   // ---------------------------------------------------------------------
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff,  in_data_in;
   logic    load;       // input register content is processed this cycle
   logic    req_take;
   logic    rsp_take;

   logic [2:0] rsp_cnt_ff, rsp_cnt_in;
   rsp_type    slot_ff [MAX_RESULTS];
   rsp_type    slot_in [MAX_RESULTS];

   assign rsp_take  = rsp_valid && !rsp_stall;
   // buffer is free when empty, or when its final entry leaves now
   assign load      = in_valid_ff &&
                      ((rsp_cnt_ff == 3'd0) || ((rsp_cnt_ff == 3'd1) && rsp_take));
   assign req_stall = in_valid_ff && !load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   // ---------------------------------------------------------------------
   // Exponent table lookup: 15 parallel compares, lowest code wins.
   // ---------------------------------------------------------------------
   logic [119:0] code_table;
   logic [7:0]   exponent;
   logic [3:0]   code;

   assign code_table = {codes_high_ff, codes_low_ff};
   assign exponent   = in_data_ff.value[14:7];

   always_comb begin
      code = '0;
      for (int c = NUM_CODES; c >= 1; c--) begin
         if ((4'(c) <= codes_used_ff) && (code_table[8*(c-1) +: 8] == exponent)) begin
            code = 4'(c);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Pack state and the per-request result set
   // ---------------------------------------------------------------------
   logic [31:0] partial_ff, partial_in;
   logic [4:0]  fill_ff,    fill_in;
   logic [15:0] column_ff,  column_in;
   logic [30:0] total_ff,   total_in;

   logic [11:0] unit;
   logic [43:0] acc;
   logic        word_full;
   logic [31:0] new_partial;
   logic [4:0]  new_fill;
   logic        escaped;
   logic [30:0] new_total;
   logic [15:0] eff_len;
   logic [16:0] column_next;
   logic        row_end;
   logic [2:0]  n_res;
   rsp_type     new_slot [MAX_RESULTS];
   rsp_type     blank;

   assign unit      = {in_data_ff.value[15], code, in_data_ff.value[6:0]};
   assign acc       = {12'd0, partial_ff} | ({32'd0, unit} << fill_ff);
   assign word_full = ({1'b0, fill_ff} + 6'(UNIT_BITS)) >= 6'(WORD_BITS);
   assign new_partial = word_full ? {20'd0, acc[43:32]} : acc[31:0];
   assign new_fill    = word_full ? 5'(fill_ff + 5'(UNIT_BITS))      // wraps past 32
                                  : fill_ff + 5'(UNIT_BITS);
   assign escaped   = (code == 4'd0);
   assign new_total = (escaped && (total_ff != PATCH_TOTAL_MAX)) ? total_ff + 31'd1
                                                                  : total_ff;
   // zero-length rows count as length one
   assign eff_len     = (row_length_ff == 16'd0) ? 16'd1 :
                        (row_length_ff > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : row_length_ff;
   assign column_next = {1'b0, column_ff} + 17'd1;
   assign row_end     = column_next >= {1'b0, eff_len};

   always_comb begin
      blank = '0;
      n_res = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         new_slot[i] = blank;
      end
      if (word_full) begin
         new_slot[n_res[1:0]].kind        = KIND_WORD;
         new_slot[n_res[1:0]].packed_word = acc[31:0];
         n_res = n_res + 3'd1;
      end
      if (in_data_ff.last && (new_fill != 5'd0)) begin
         new_slot[n_res[1:0]].kind        = KIND_WORD;
         new_slot[n_res[1:0]].packed_word = new_partial;
         n_res = n_res + 3'd1;
      end
      if (escaped) begin
         new_slot[n_res[1:0]].kind          = KIND_PATCH;
         new_slot[n_res[1:0]].patch_column  = column_ff;
         new_slot[n_res[1:0]].patch_correct = in_data_ff.value;
         new_slot[n_res[1:0]].patch_wrong   = marker_ff;
         n_res = n_res + 3'd1;
      end
      if (row_end || in_data_ff.last) begin
         new_slot[n_res[1:0]].kind       = KIND_COUNT;
         new_slot[n_res[1:0]].row_offset = new_total;
         n_res = n_res + 3'd1;
      end
      // tag the closing result of this request
      if (n_res != 3'd0) begin
         new_slot[2'(n_res - 3'd1)].final_res = 1'b1;
      end
   end

   always_comb begin
      partial_in = partial_ff;
      fill_in    = fill_ff;
      column_in  = column_ff;
      total_in   = total_ff;
      if (load) begin
         if (in_data_ff.last) begin
            partial_in = '0;
            fill_in    = '0;
            column_in  = '0;
            total_in   = '0;
         end else begin
            partial_in = new_partial;
            fill_in    = new_fill;
            column_in  = row_end ? 16'd0 : column_next[15:0];
            total_in   = new_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
         column_ff  <= '0;
         total_ff   <= '0;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
         column_ff  <= column_in;
         total_ff   <= total_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result buffer: up to four entries, head at slot 0, shifts on pop.
   // A load only happens once the buffer drains, so it simply overwrites.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_cnt_in = rsp_cnt_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (load) begin
         rsp_cnt_in = n_res;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_in[i] = new_slot[i];
         end
      end else if (rsp_take) begin
         rsp_cnt_in = rsp_cnt_ff - 3'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_cnt_ff <= '0;
      end else begin
         rsp_cnt_ff <= rsp_cnt_in;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_valid = (rsp_cnt_ff != 3'd0);
   assign rsp_data  = slot_ff[0];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff <= 3'(MAX_RESULTS))
      else $error("result buffer count out of range");

   a_fill_aligned: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[1:0] == 2'b00) && (fill_ff <= 5'd28))
      else $error("fill level not a multiple of four");

   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      (partial_ff >> fill_ff) == 32'd0)
      else $error("partial word holds bits above fill level");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff != 16'hFFFF)
      else $error("column counter passed the longest row");

   a_hold_when_busy: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("pending request lost while buffer busy");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_cnt_ff == 3'd1)) |-> rsp_data.final_res)
      else $error("last buffered result not tagged final");

endmodule
